// File: rtl/line_rasterizer_unit_assert.svh
// Assertion macros shared by the line rasterizer RTL
`ifndef LINE_RASTERIZER_UNIT_ASSERT_SVH
`define LINE_RASTERIZER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define LR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("line rasterizer check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define LR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("line rasterizer check failed");

`endif

// File: rtl/lrast_pkg.sv
// Shared types and constants for the line rasterizer
package lrast_pkg;

  // Frame width register and linear address widths
  localparam int unsigned FRAME_W_BITS = 13;
  localparam int unsigned ADDR_BITS    = 24;
  localparam logic [FRAME_W_BITS-1:0] FRAME_W_RESET = 13'd640;

  // Input beat commands
  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_e;

endpackage

// File: rtl/lrast_axis.sv
// One axis of the rasterizer step: error accumulate, step decision, saturate
module lrast_axis import lrast_pkg::*; #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic [COORD_BITS-1:0]        cur_i,
  input  logic signed [COORD_BITS+1:0] err_i,
  input  logic [COORD_BITS-1:0]        delta_own_i,
  input  logic [COORD_BITS-1:0]        delta_cross_i,
  input  logic                         dir_neg_i,
  output logic [COORD_BITS-1:0]        cur_o,
  output logic signed [COORD_BITS+1:0] err_o
);

  localparam int unsigned ERR_W = COORD_BITS + 2;
  localparam int unsigned EXT_W = COORD_BITS + 4;
  localparam logic signed [EXT_W-1:0] ERR_MAX = EXT_W'((1 << (COORD_BITS + 1)) - 1);
  localparam logic signed [EXT_W-1:0] ERR_MIN = EXT_W'(-(1 << (COORD_BITS + 1)));

  logic signed [EXT_W-1:0] sum;
  logic signed [EXT_W-1:0] cross_ext;
  logic signed [EXT_W-1:0] adj;
  logic                    take_step;

  // accumulate own delta, step when twice the error reaches the other delta
  always_comb begin
    sum       = $signed({{(EXT_W-ERR_W){err_i[ERR_W-1]}}, err_i})
              + $signed({{(EXT_W-COORD_BITS){1'b0}}, delta_own_i});
    cross_ext = $signed({{(EXT_W-COORD_BITS){1'b0}}, delta_cross_i});
    take_step = (sum <<< 1) >= cross_ext;
    adj       = take_step ? (sum - cross_ext) : sum;
  end

  // coordinate moves one place, wrapping
  always_comb begin
    if (!take_step) begin
      cur_o = cur_i;
    end else if (dir_neg_i) begin
      cur_o = cur_i - COORD_BITS'(1);
    end else begin
      cur_o = cur_i + COORD_BITS'(1);
    end
  end

  // saturate back into the accumulator range
  always_comb begin
    priority if (adj > ERR_MAX) begin
      err_o = ERR_MAX[ERR_W-1:0];
    end else if (adj < ERR_MIN) begin
      err_o = ERR_MIN[ERR_W-1:0];
    end else begin
      err_o = adj[ERR_W-1:0];
    end
  end

endmodule

// File: rtl/line_rasterizer_unit.sv
// Top level of the line rasterizer: step logic, pixel stage and address stage
`include "line_rasterizer_unit_assert.svh"

// Line rasterizer. A start beat (opcode 0) loads both endpoints and yields the
// first pixel; each step beat (opcode 1) yields the next pixel of the line, with
// last_pixel set on the end point, after which the unit is idle and a step beat
// yields an all-zero result with pixel_valid low. One input beat is taken every
// cycle unless in_stall_o is high, and exactly one result beat follows: the
// per-axis error update that feeds back into the line state is registered into
// the pixel stage, and the frame_width * y + x multiply-add for the 24-bit
// address is registered into the output stage. frame_width is written through
// cfg_we_i/cfg_wdata_i and must only change while no beat is in flight.
module line_rasterizer_unit import lrast_pkg::*; #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration
  input  logic                    cfg_we_i,
  input  logic [FRAME_W_BITS-1:0] cfg_wdata_i,
  // input channel
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    opcode_i,
  input  logic [COORD_BITS-1:0]   start_x_i,
  input  logic [COORD_BITS-1:0]   start_y_i,
  input  logic [COORD_BITS-1:0]   end_x_i,
  input  logic [COORD_BITS-1:0]   end_y_i,
  // output channel
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    pixel_valid_o,
  output logic [COORD_BITS-1:0]   pixel_x_o,
  output logic [COORD_BITS-1:0]   pixel_y_o,
  output logic [ADDR_BITS-1:0]    pixel_address_o,
  output logic                    last_pixel_o
);

  localparam int unsigned ERR_W = COORD_BITS + 2;

  // frame width register
  logic [FRAME_W_BITS-1:0] frame_w_q;

  // line state
  logic [COORD_BITS-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [COORD_BITS-1:0] goal_x_q, goal_x_d, goal_y_q, goal_y_d;
  logic [COORD_BITS-1:0] delta_x_q, delta_x_d, delta_y_q, delta_y_d;
  logic                  dir_x_neg_q, dir_x_neg_d, dir_y_neg_q, dir_y_neg_d;
  logic signed [ERR_W-1:0] err_x_q, err_x_d, err_y_q, err_y_d;
  logic                  line_active_q, line_active_d;

  // step results from the axis units
  logic [COORD_BITS-1:0]   step_x, step_y;
  logic signed [ERR_W-1:0] step_err_x, step_err_y;

  // pixel stage
  logic                  mid_valid_q;
  logic                  mid_pix_valid_q, mid_pix_valid_d;
  logic [COORD_BITS-1:0] mid_x_q, mid_x_d, mid_y_q, mid_y_d;
  logic                  mid_last_q, mid_last_d;

  // output stage
  logic                  out_valid_q;
  logic                  out_pix_valid_q;
  logic [COORD_BITS-1:0] out_x_q, out_y_q;
  logic [ADDR_BITS-1:0]  out_addr_q, addr_d;
  logic                  out_last_q;

  // handshake
  logic in_acc;
  logic out_load;

  assign out_load   = mid_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = mid_valid_q && !out_load;
  assign in_acc     = in_valid_i && !in_stall_o;

  // frame width config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_w_q <= FRAME_W_RESET;
    end else if (cfg_we_i) begin
      frame_w_q <= cfg_wdata_i;
    end
  end

  // per-axis error update
  lrast_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
    .cur_i         (cur_x_q),
    .err_i         (err_x_q),
    .delta_own_i   (delta_x_q),
    .delta_cross_i (delta_y_q),
    .dir_neg_i     (dir_x_neg_q),
    .cur_o         (step_x),
    .err_o         (step_err_x)
  );

  lrast_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
    .cur_i         (cur_y_q),
    .err_i         (err_y_q),
    .delta_own_i   (delta_y_q),
    .delta_cross_i (delta_x_q),
    .dir_neg_i     (dir_y_neg_q),
    .cur_o         (step_y),
    .err_o         (step_err_y)
  );

  // next line state and pixel for the incoming beat
  always_comb begin
    cur_x_d         = cur_x_q;
    cur_y_d         = cur_y_q;
    goal_x_d        = goal_x_q;
    goal_y_d        = goal_y_q;
    delta_x_d       = delta_x_q;
    delta_y_d       = delta_y_q;
    dir_x_neg_d     = dir_x_neg_q;
    dir_y_neg_d     = dir_y_neg_q;
    err_x_d         = err_x_q;
    err_y_d         = err_y_q;
    line_active_d   = line_active_q;
    mid_pix_valid_d = 1'b0;
    mid_x_d         = '0;
    mid_y_d         = '0;
    mid_last_d      = 1'b0;
    if (opcode_i == OP_START) begin
      cur_x_d     = start_x_i;
      cur_y_d     = start_y_i;
      goal_x_d    = end_x_i;
      goal_y_d    = end_y_i;
      dir_x_neg_d = !(start_x_i < end_x_i);
      dir_y_neg_d = !(start_y_i < end_y_i);
      delta_x_d   = (start_x_i < end_x_i) ? (end_x_i - start_x_i) : (start_x_i - end_x_i);
      delta_y_d   = (start_y_i < end_y_i) ? (end_y_i - start_y_i) : (start_y_i - end_y_i);
      err_x_d     = '0;
      err_y_d     = '0;
    end else if (line_active_q) begin
      cur_x_d = step_x;
      cur_y_d = step_y;
      err_x_d = step_err_x;
      err_y_d = step_err_y;
    end
    // a pixel comes out of every start, and of a step on an active line
    if (opcode_i == OP_START || line_active_q) begin
      mid_pix_valid_d = 1'b1;
      mid_x_d         = cur_x_d;
      mid_y_d         = cur_y_d;
      mid_last_d      = (cur_x_d == goal_x_d) && (cur_y_d == goal_y_d);
      line_active_d   = !mid_last_d;
    end
  end

  // line state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q       <= '0;
      cur_y_q       <= '0;
      goal_x_q      <= '0;
      goal_y_q      <= '0;
      delta_x_q     <= '0;
      delta_y_q     <= '0;
      dir_x_neg_q   <= 1'b0;
      dir_y_neg_q   <= 1'b0;
      err_x_q       <= '0;
      err_y_q       <= '0;
      line_active_q <= 1'b0;
    end else if (in_acc) begin
      cur_x_q       <= cur_x_d;
      cur_y_q       <= cur_y_d;
      goal_x_q      <= goal_x_d;
      goal_y_q      <= goal_y_d;
      delta_x_q     <= delta_x_d;
      delta_y_q     <= delta_y_d;
      dir_x_neg_q   <= dir_x_neg_d;
      dir_y_neg_q   <= dir_y_neg_d;
      err_x_q       <= err_x_d;
      err_y_q       <= err_y_d;
      line_active_q <= line_active_d;
    end
  end

  // pixel stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_valid_q <= 1'b0;
    end else if (in_acc) begin
      mid_valid_q <= 1'b1;
    end else if (out_load) begin
      mid_valid_q <= 1'b0;
    end
  end

  // pixel stage payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mid_pix_valid_q <= mid_pix_valid_d;
      mid_x_q         <= mid_x_d;
      mid_y_q         <= mid_y_d;
      mid_last_q      <= mid_last_d;
    end
  end

  // linear address, wraps to the address width
  assign addr_d = ADDR_BITS'(frame_w_q) * ADDR_BITS'(mid_y_q) + ADDR_BITS'(mid_x_q);

  // output stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output stage payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_pix_valid_q <= mid_pix_valid_q;
      out_x_q         <= mid_x_q;
      out_y_q         <= mid_y_q;
      out_addr_q      <= addr_d;
      out_last_q      <= mid_last_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pixel_valid_o   = out_pix_valid_q;
  assign pixel_x_o       = out_x_q;
  assign pixel_y_o       = out_y_q;
  assign pixel_address_o = out_addr_q;
  assign last_pixel_o    = out_last_q;

  // checks
  `LR_ASSERT_NEXT(a_idle_step_blank, in_acc && opcode_i == OP_STEP && !line_active_q,
                  mid_valid_q && !mid_pix_valid_q)
  `LR_ASSERT_IMPL(a_last_goes_idle, mid_valid_q && mid_last_q, !line_active_q)
  `LR_ASSERT_IMPL(a_blank_beat_zero, out_valid_q && !out_pix_valid_q,
                  out_addr_q == '0 && !out_last_q)
  `LR_ASSERT_IMPL(a_stall_only_full, in_stall_o, mid_valid_q && out_valid_q)

endmodule
